FILE: hw/rtl/npq_pkg.sv
// ============================================================================
// npq_pkg: shared types and constants of the nearest palette quantizer
// Holds the channel beat formats, the item format handed along the cell
// chain, the configuration register indexes and their reset values.
// ============================================================================
`default_nettype none

package npq_pkg;

   localparam int PALETTE_ENTRIES_DEFAULT = 256;
   localparam int INDEX_WIDTH             = 8;
   localparam int CHANNEL_WIDTH           = 8;
   localparam int PIXEL_WIDTH             = 24;
   localparam int DIST_WIDTH              = 18;
   localparam int CSR_INDEX_WIDTH         = 3;
   localparam int CSR_DATA_WIDTH          = 4;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SOURCE_FORMAT     = 3'd0,
      CSR_RED_POSITION      = 3'd1,
      CSR_GREEN_POSITION    = 3'd2,
      CSR_RED_SCALE_SHIFT   = 3'd3,
      CSR_GREEN_SCALE_SHIFT = 3'd4,
      CSR_BLUE_SCALE_SHIFT  = 3'd5
   } csr_index_type;

   typedef enum logic {
      CMD_LOAD     = 1'b0,
      CMD_QUANTIZE = 1'b1
   } command_type;

   typedef enum logic {
      FORMAT_BGR24    = 1'b0,
      FORMAT_PACKED16 = 1'b1
   } source_format_type;

   localparam logic       SOURCE_FORMAT_RESET     = FORMAT_BGR24;
   localparam logic [3:0] RED_POSITION_RESET      = 4'd11;
   localparam logic [3:0] GREEN_POSITION_RESET    = 4'd5;
   localparam logic [2:0] RED_SCALE_SHIFT_RESET   = 3'd3;
   localparam logic [2:0] GREEN_SCALE_SHIFT_RESET = 3'd2;
   localparam logic [2:0] BLUE_SCALE_SHIFT_RESET  = 3'd3;

   typedef struct packed {
      logic                     command;
      logic [INDEX_WIDTH-1:0]   entry_index;
      logic [CHANNEL_WIDTH-1:0] entry_red;
      logic [CHANNEL_WIDTH-1:0] entry_green;
      logic [CHANNEL_WIDTH-1:0] entry_blue;
      logic [PIXEL_WIDTH-1:0]   pixel_data;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] color_index;
   } rsp_payload_type;

   // For a load the colour fields carry the entry, for a pixel the pixel.
   typedef struct packed {
      logic                     quantize;
      logic [INDEX_WIDTH-1:0]   entry_index;
      logic [CHANNEL_WIDTH-1:0] red;
      logic [CHANNEL_WIDTH-1:0] green;
      logic [CHANNEL_WIDTH-1:0] blue;
      logic [DIST_WIDTH-1:0]    best_dist;
      logic [INDEX_WIDTH-1:0]   best_index;
   } chain_item_type;

endpackage

`default_nettype wire

FILE: hw/rtl/npq_stream_if.sv
// ============================================================================
// npq_stream_if: valid/ready channel
// One beat moves at a rising edge where valid and ready are both high.
// ============================================================================
`default_nettype none

interface npq_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/nearest_palette_quantizer.sv
// Throughput: one beat per cycle, loads and pixels alike, set by the cell chain
// in which every cell holds one palette entry and takes two stages.
// A stalled result register holds the whole chain.
// Reset returns the configuration registers to their reset values and clears all valid flags; palette
// entries are not cleared and must be loaded before use.
// ============================================================================
// nearest_palette_quantizer: nearest palette colour search
// Front unpack stage, a chain of palette cells, and the result register.
// ============================================================================
`default_nettype none

module nearest_palette_quantizer #(
   parameter int PALETTE_ENTRIES = npq_pkg::PALETTE_ENTRIES_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   npq_stream_if.sink                               req_bus,
   npq_stream_if.source                             rsp_bus,
   input  wire logic                                csr_write_enable,
   input  wire logic [npq_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [npq_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic                    advance;
   logic                    chain_valid [PALETTE_ENTRIES+1];
   npq_pkg::chain_item_type chain_item  [PALETTE_ENTRIES+1];

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [npq_pkg::INDEX_WIDTH-1:0] rsp_index_ff;

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   npq_unpack u_unpack (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .in_valid         (req_bus.valid),
      .in_payload       (req_bus.payload),
      .out_valid        (chain_valid[0]),
      .out_item         (chain_item[0])
   );

   for (genvar g = 0; g < PALETTE_ENTRIES; g++) begin : g_cell
      npq_cell #(
         .CELL_INDEX (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_valid[g]),
         .in_item   (chain_item[g]),
         .out_valid (chain_valid[g+1]),
         .out_item  (chain_item[g+1])
      );
   end

   assign rsp_valid_in = chain_valid[PALETTE_ENTRIES] && chain_item[PALETTE_ENTRIES].quantize;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_index_ff <= chain_item[PALETTE_ENTRIES].best_index;
      end
   end

   assign rsp_bus.valid               = rsp_valid_ff;
   assign rsp_bus.payload.color_index = rsp_index_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/npq_unpack.sv
// ============================================================================
// npq_unpack: configuration registers and pixel unpacking front stage
// Holds the format registers, turns each request beat into a chain item
// and registers it at the head of the cell chain.
// ============================================================================
`default_nettype none

module npq_unpack (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  advance,
   input  wire logic                                  csr_write_enable,
   input  wire logic [npq_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [npq_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data,
   input  wire logic                                  in_valid,
   input  wire npq_pkg::req_payload_type              in_payload,
   output logic                                       out_valid,
   output npq_pkg::chain_item_type                    out_item
);

   logic       source_format_ff;
   logic [3:0] red_position_ff;
   logic [3:0] green_position_ff;
   logic [2:0] red_scale_ff;
   logic [2:0] green_scale_ff;
   logic [2:0] blue_scale_ff;

   logic                    valid_ff;
   npq_pkg::chain_item_type item_ff;
   npq_pkg::chain_item_type item_in;

   logic [15:0]                       word;
   logic [npq_pkg::CHANNEL_WIDTH-1:0] red_field;
   logic [npq_pkg::CHANNEL_WIDTH-1:0] green_field;
   logic [npq_pkg::CHANNEL_WIDTH-1:0] red_value;
   logic [npq_pkg::CHANNEL_WIDTH-1:0] green_value;
   logic [npq_pkg::CHANNEL_WIDTH-1:0] blue_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_format_ff  <= npq_pkg::SOURCE_FORMAT_RESET;
         red_position_ff   <= npq_pkg::RED_POSITION_RESET;
         green_position_ff <= npq_pkg::GREEN_POSITION_RESET;
         red_scale_ff      <= npq_pkg::RED_SCALE_SHIFT_RESET;
         green_scale_ff    <= npq_pkg::GREEN_SCALE_SHIFT_RESET;
         blue_scale_ff     <= npq_pkg::BLUE_SCALE_SHIFT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            npq_pkg::CSR_SOURCE_FORMAT:     source_format_ff  <= csr_write_data[0];
            npq_pkg::CSR_RED_POSITION:      red_position_ff   <= csr_write_data;
            npq_pkg::CSR_GREEN_POSITION:    green_position_ff <= csr_write_data;
            npq_pkg::CSR_RED_SCALE_SHIFT:   red_scale_ff      <= csr_write_data[2:0];
            npq_pkg::CSR_GREEN_SCALE_SHIFT: green_scale_ff    <= csr_write_data[2:0];
            npq_pkg::CSR_BLUE_SCALE_SHIFT:  blue_scale_ff     <= csr_write_data[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      word        = in_payload.pixel_data[15:0];
      red_field   = 8'(word >> red_position_ff);
      green_field = 8'(word >> green_position_ff);
      red_value   = 8'(red_field << red_scale_ff);
      green_value = 8'(green_field << green_scale_ff);
      blue_value  = 8'(word[7:0] << blue_scale_ff);

      item_in.quantize    = (in_payload.command == npq_pkg::CMD_QUANTIZE);
      item_in.entry_index = in_payload.entry_index;
      item_in.best_dist   = '1;
      item_in.best_index  = '0;
      if (in_payload.command == npq_pkg::CMD_LOAD) begin
         item_in.red   = in_payload.entry_red;
         item_in.green = in_payload.entry_green;
         item_in.blue  = in_payload.entry_blue;
      end else if (source_format_ff == npq_pkg::FORMAT_PACKED16) begin
         item_in.red   = red_value;
         item_in.green = green_value;
         item_in.blue  = blue_value;
      end else begin
         item_in.red   = in_payload.pixel_data[23:16];
         item_in.green = in_payload.pixel_data[15:8];
         item_in.blue  = in_payload.pixel_data[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/npq_cell.sv
// ============================================================================
// npq_cell: one palette entry of the search chain
// Stores its entry, takes loads addressed to it, and for a pixel computes
// the squared distance in one stage and updates the running best in the next.
// ============================================================================
`default_nettype none

module npq_cell #(
   parameter int CELL_INDEX = 0
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic                    in_valid,
   input  wire npq_pkg::chain_item_type in_item,
   output logic                         out_valid,
   output npq_pkg::chain_item_type      out_item
);

   localparam logic [npq_pkg::INDEX_WIDTH-1:0] SLOT = npq_pkg::INDEX_WIDTH'(CELL_INDEX);

   logic [npq_pkg::CHANNEL_WIDTH-1:0] red_ff;
   logic [npq_pkg::CHANNEL_WIDTH-1:0] green_ff;
   logic [npq_pkg::CHANNEL_WIDTH-1:0] blue_ff;

   logic                              mid_valid_ff;
   npq_pkg::chain_item_type           mid_item_ff;
   logic [npq_pkg::DIST_WIDTH-1:0]    dist_ff;
   logic [npq_pkg::DIST_WIDTH-1:0]    dist_in;

   logic                              out_valid_ff;
   npq_pkg::chain_item_type           out_item_ff;
   npq_pkg::chain_item_type           out_item_in;

   logic                              write_entry;
   logic [npq_pkg::CHANNEL_WIDTH-1:0] diff_red;
   logic [npq_pkg::CHANNEL_WIDTH-1:0] diff_green;
   logic [npq_pkg::CHANNEL_WIDTH-1:0] diff_blue;
   logic [15:0]                       sq_red;
   logic [15:0]                       sq_green;
   logic [15:0]                       sq_blue;

   assign write_entry = advance && in_valid && !in_item.quantize && (in_item.entry_index == SLOT);

   always_ff @(posedge clock) begin
      if (write_entry) begin
         red_ff   <= in_item.red;
         green_ff <= in_item.green;
         blue_ff  <= in_item.blue;
      end
   end

   always_comb begin
      diff_red   = (in_item.red > red_ff) ? (in_item.red - red_ff) : (red_ff - in_item.red);
      diff_green = (in_item.green > green_ff) ? (in_item.green - green_ff)
                                              : (green_ff - in_item.green);
      diff_blue  = (in_item.blue > blue_ff) ? (in_item.blue - blue_ff) : (blue_ff - in_item.blue);
      sq_red     = diff_red * diff_red;
      sq_green   = diff_green * diff_green;
      sq_blue    = diff_blue * diff_blue;
      dist_in    = npq_pkg::DIST_WIDTH'(sq_red) + npq_pkg::DIST_WIDTH'(sq_green)
                 + npq_pkg::DIST_WIDTH'(sq_blue);
   end

   always_comb begin
      out_item_in = mid_item_ff;
      if (mid_item_ff.quantize && (dist_ff < mid_item_ff.best_dist)) begin
         out_item_in.best_dist  = dist_ff;
         out_item_in.best_index = SLOT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         mid_valid_ff <= in_valid;
         out_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mid_item_ff <= in_item;
         dist_ff     <= dist_in;
         out_item_ff <= out_item_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/npq_checker.sv
// ============================================================================
// npq_checker: port checks for the nearest palette quantizer
// Watches the request and result channels at the top level's ports.
// ============================================================================
`default_nettype none

module npq_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [npq_pkg::INDEX_WIDTH-1:0] rsp_color_index
);

   // A result beat waiting to be taken stays offered.
   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat withdrawn while stalled");

   // A stalled result beat keeps its index.
   a_rsp_index_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_color_index))
      else $error("result index changed while stalled");

   // Requests are refused only while a result beat is stuck.
   a_req_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow result stall");

   // Nothing comes out right after reset.
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat offered right after reset");

endmodule

bind nearest_palette_quantizer npq_checker u_npq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_color_index (rsp_bus.payload.color_index)
);

`default_nettype wire

FILE: tb/sv/tb_nearest_palette_quantizer.sv
// ============================================================================
// tb_nearest_palette_quantizer: self-checking testbench of the quantizer
// Loads a grey ramp into the palette, walks a table of directed beats, then
// sends random loads and pixels under a range of register settings while both
// channel ends stall at random. Each result beat is checked against its row's
// answer if typed, else against a search over a shadow palette copy in the bench.
// ============================================================================
`default_nettype none

module tb_nearest_palette_quantizer;
   import npq_pkg::*;

   localparam int PALETTE_SIZE    = PALETTE_ENTRIES_DEFAULT;
   localparam int CHAIN_LATENCY   = 2 * PALETTE_SIZE + 2;
   localparam int HOLD_OFF_CYCLES = 3000;
   localparam int PHASE_COUNT     = 10;
   localparam int PRESSURE_PHASE  = 3;
   localparam int PRESSURE_BEATS  = 600;
   localparam int PHASE_BEATS     = 20;

   typedef enum logic [1:0] {
      ROW_LOAD,
      ROW_PIXEL,
      ROW_REGS
   } row_kind_type;

   // The data field holds a colour {red, green, blue} for a load, the pixel word
   // for a pixel, and six 4-bit register values, index 0 first, for a write.
   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   slot;
      logic [23:0]  data;
      logic         typed;
      logic [7:0]   answer;
   } table_row_type;

   localparam table_row_type DIRECTED_ROWS [25] = '{
      '{ROW_PIXEL, 8'd0,   24'h000000, 1'b1, 8'd0},
      '{ROW_PIXEL, 8'd0,   24'hFFFFFF, 1'b1, 8'd255},
      '{ROW_PIXEL, 8'd0,   24'h808080, 1'b1, 8'd128},
      '{ROW_PIXEL, 8'd0,   24'hFF0000, 1'b0, 8'd0},
      '{ROW_PIXEL, 8'd0,   24'h00FF7F, 1'b0, 8'd0},
      '{ROW_LOAD,  8'd200, 24'h646464, 1'b0, 8'd0},
      '{ROW_PIXEL, 8'd0,   24'h646464, 1'b1, 8'd100},
      '{ROW_LOAD,  8'd3,   24'h323232, 1'b0, 8'd0},
      '{ROW_PIXEL, 8'd0,   24'h323232, 1'b1, 8'd3},
      '{ROW_LOAD,  8'd0,   24'hFF00FF, 1'b0, 8'd0},
      '{ROW_PIXEL, 8'd0,   24'h000000, 1'b1, 8'd1},
      '{ROW_PIXEL, 8'd0,   24'hFF00FF, 1'b1, 8'd0},
      '{ROW_LOAD,  8'd255, 24'h000000, 1'b0, 8'd0},
      '{ROW_PIXEL, 8'd0,   24'h000000, 1'b1, 8'd255},
      '{ROW_REGS,  8'd0,   24'h1B5323, 1'b0, 8'd0},
      '{ROW_PIXEL, 8'd0,   24'hFF0000, 1'b1, 8'd255},
      '{ROW_PIXEL, 8'd0,   24'h00FFFF, 1'b0, 8'd0},
      '{ROW_PIXEL, 8'd0,   24'h005A5A, 1'b0, 8'd0},
      '{ROW_REGS,  8'd0,   24'h1FF777, 1'b0, 8'd0},
      '{ROW_PIXEL, 8'd0,   24'h00FFFF, 1'b1, 8'd128},
      '{ROW_REGS,  8'd0,   24'h100000, 1'b0, 8'd0},
      '{ROW_PIXEL, 8'd0,   24'h001234, 1'b1, 8'd52},
      '{ROW_PIXEL, 8'd0,   24'hAB00FF, 1'b0, 8'd0},
      '{ROW_REGS,  8'd0,   24'hE849DE, 1'b0, 8'd0},
      '{ROW_PIXEL, 8'd0,   24'h808080, 1'b1, 8'd128}
   };

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_write_enable;
   csr_index_type             csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_write_data;

   npq_stream_if #(.payload_type(req_payload_type)) req_bus ();
   npq_stream_if #(.payload_type(rsp_payload_type)) rsp_bus ();

   nearest_palette_quantizer #(.PALETTE_ENTRIES(PALETTE_SIZE)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   logic [7:0] shadow_red   [PALETTE_SIZE];
   logic [7:0] shadow_green [PALETTE_SIZE];
   logic [7:0] shadow_blue  [PALETTE_SIZE];

   logic       format_setting      = SOURCE_FORMAT_RESET;
   logic [3:0] red_pos_setting     = RED_POSITION_RESET;
   logic [3:0] green_pos_setting   = GREEN_POSITION_RESET;
   logic [2:0] red_scale_setting   = RED_SCALE_SHIFT_RESET;
   logic [2:0] green_scale_setting = GREEN_SCALE_SHIFT_RESET;
   logic [2:0] blue_scale_setting  = BLUE_SCALE_SHIFT_RESET;

   logic [7:0] expected_indices [$];
   int         mismatch_count   = 0;
   bit         quiet_tail       = 1'b0;
   bit         hold_off_request = 1'b0;

   always #10 clock = ~clock;

   function automatic logic [23:0] unpack_pixel(input logic [23:0] pixel);
      logic [15:0] word;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      word  = pixel[15:0];
      red   = 8'(8'(word >> red_pos_setting) << red_scale_setting);
      green = 8'(8'(word >> green_pos_setting) << green_scale_setting);
      blue  = 8'(word[7:0] << blue_scale_setting);
      return (format_setting == FORMAT_BGR24) ? pixel : {red, green, blue};
   endfunction

   function automatic logic [7:0] nearest_entry(input logic [23:0] colour);
      int         k;
      int         dr;
      int         dg;
      int         db;
      int         distance;
      int         best_distance;
      logic [7:0] best;
      best          = '0;
      best_distance = 1 << 30;
      for (k = 0; k < PALETTE_SIZE; k++) begin
         dr       = int'(colour[23:16]) - int'(shadow_red[k]);
         dg       = int'(colour[15:8]) - int'(shadow_green[k]);
         db       = int'(colour[7:0]) - int'(shadow_blue[k]);
         distance = dr * dr + dg * dg + db * db;
         if (distance < best_distance) begin
            best          = 8'(k);
            best_distance = distance;
         end
      end
      return best;
   endfunction

   function automatic req_payload_type random_beat();
      req_payload_type beat;
      beat.command     = 1'($urandom_range(1));
      beat.entry_index = 8'($urandom);
      beat.entry_red   = 8'($urandom);
      beat.entry_green = 8'($urandom);
      beat.entry_blue  = 8'($urandom);
      beat.pixel_data  = 24'($urandom);
      return beat;
   endfunction

   function automatic req_payload_type mixed_beat();
      req_payload_type beat;
      int              source;
      beat   = random_beat();
      source = $urandom_range(PALETTE_SIZE - 1);
      if ($urandom_range(4) == 0) begin
         beat.command = CMD_LOAD;
         // Copying another entry makes ties between indexes come up.
         if ($urandom_range(2) == 0) begin
            {beat.entry_red, beat.entry_green, beat.entry_blue} =
               {shadow_red[source], shadow_green[source], shadow_blue[source]};
         end
      end else begin
         beat.command = CMD_QUANTIZE;
         if ($urandom_range(2) == 0 && format_setting == FORMAT_BGR24) begin
            beat.pixel_data = {shadow_red[source], shadow_green[source], shadow_blue[source]};
         end
      end
      return beat;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   task automatic send_beat(input req_payload_type beat, input logic typed,
                            input logic [7:0] answer);
      if (!quiet_tail && $urandom_range(7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= beat;
      do @(posedge clock); while (!req_bus.ready);
      if (beat.command == CMD_LOAD) begin
         shadow_red[beat.entry_index]   = beat.entry_red;
         shadow_green[beat.entry_index] = beat.entry_green;
         shadow_blue[beat.entry_index]  = beat.entry_blue;
      end else begin
         expected_indices.push_back(typed ? answer
                                          : nearest_entry(unpack_pixel(beat.pixel_data)));
      end
   endtask

   task automatic settle_block();
      req_bus.valid <= 1'b0;
      while (expected_indices.size() != 0) @(posedge clock);
      repeat (CHAIN_LATENCY) @(posedge clock);
   endtask

   task automatic program_registers(input logic [23:0] values);
      int            i;
      logic [3:0]    value;
      csr_index_type target;
      for (i = 0; i < 6; i++) begin
         value  = values[23 - 4 * i -: 4];
         target = csr_index_type'(i);
         csr_write_enable <= 1'b1;
         csr_index        <= target;
         csr_write_data   <= value;
         case (target)
            CSR_SOURCE_FORMAT:     format_setting      = value[0];
            CSR_RED_POSITION:      red_pos_setting     = value;
            CSR_GREEN_POSITION:    green_pos_setting   = value;
            CSR_RED_SCALE_SHIFT:   red_scale_setting   = value[2:0];
            CSR_GREEN_SCALE_SHIFT: green_scale_setting = value[2:0];
            CSR_BLUE_SCALE_SHIFT:  blue_scale_setting  = value[2:0];
            default: ;
         endcase
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_indices.size() == 0) begin
            report_mismatch($sformatf("result beat with index %0d but none outstanding",
                                      rsp_bus.payload.color_index));
         end else if (rsp_bus.payload.color_index !== expected_indices[0]) begin
            report_mismatch($sformatf("color_index %0d, expected %0d",
                                      rsp_bus.payload.color_index, expected_indices[0]));
            void'(expected_indices.pop_front());
         end else begin
            void'(expected_indices.pop_front());
         end
      end
   end

   initial begin : result_side
      int pause;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (!quiet_tail && $urandom_range(11) == 0) begin
            pause = $urandom_range(1, 16);
            rsp_bus.ready <= 1'b0;
            repeat (pause) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      req_payload_type beat;
      table_row_type   row;
      logic [23:0]     regs;
      int              slot;
      int              phase;
      int              count;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_SOURCE_FORMAT;
      csr_write_data   <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.payload  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Every entry holds a grey level equal to its own index to begin with.
      for (slot = 0; slot < PALETTE_SIZE; slot++) begin
         beat             = random_beat();
         beat.command     = CMD_LOAD;
         beat.entry_index = 8'(slot);
         beat.entry_red   = 8'(slot);
         beat.entry_green = 8'(slot);
         beat.entry_blue  = 8'(slot);
         send_beat(beat, 1'b0, '0);
      end

      foreach (DIRECTED_ROWS[i]) begin
         row  = DIRECTED_ROWS[i];
         beat = random_beat();
         case (row.kind)
            ROW_REGS: begin
               settle_block();
               program_registers(row.data);
            end
            ROW_LOAD: begin
               beat.command     = CMD_LOAD;
               beat.entry_index = row.slot;
               {beat.entry_red, beat.entry_green, beat.entry_blue} = row.data;
               send_beat(beat, 1'b0, '0);
            end
            default: begin
               beat.command    = CMD_QUANTIZE;
               beat.pixel_data = row.data;
               send_beat(beat, row.typed, row.answer);
            end
         endcase
      end

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         settle_block();
         regs     = 24'($urandom);
         regs[20] = (phase % 2 == 1);
         program_registers(regs);
         quiet_tail = (phase == PHASE_COUNT - 1);
         if (phase == PRESSURE_PHASE) begin
            hold_off_request = 1'b1;
         end
         count = (phase == PRESSURE_PHASE) ? PRESSURE_BEATS : PHASE_BEATS;
         repeat (count) send_beat(mixed_beat(), 1'b0, '0);
      end

      settle_block();
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/npq_pkg.sv
hw/rtl/npq_stream_if.sv
hw/rtl/npq_unpack.sv
hw/rtl/npq_cell.sv
hw/rtl/nearest_palette_quantizer.sv
hw/rtl/npq_checker.sv
tb/sv/tb_nearest_palette_quantizer.sv
